// ===== hw/rtl/csrv_pkg.sv =====
// ----------------------------------------------------------------------------
// csrv_pkg: shared types and constants for the clipped standardized variance
// Field widths, fixed-point format, register indexes and the control
// bundle that drives the shared divider.
// ----------------------------------------------------------------------------
package csrv_pkg;

  // Fixed-point format: fractional bits of z, sample_value and row_sd
  localparam int FRAC_BITS = 16;

  localparam int VAL_W  = 32;                 // sample_value, row_mean
  localparam int SD_W   = 31;                 // row_sd, clip_limit, divisor
  localparam int CNT_W  = 24;                 // num_columns, sample_count
  localparam int ACC_W  = 64;                 // square_sum, row_variance
  localparam int DIFF_W = VAL_W + 1;          // value - mean
  localparam int ZQ_BITS = 31;                // quotient bits kept for z
  localparam int DIVD_W = DIFF_W + FRAC_BITS; // scaled dividend for z
  localparam int HI_W   = DIVD_W - ZQ_BITS;   // dividend bits above quotient
  localparam int ITER_W = $clog2(ACC_W + 1);

  // Configuration register indexes
  localparam logic CFG_CLIP_LIMIT  = 1'b0;
  localparam logic CFG_NUM_COLUMNS = 1'b1;

  localparam logic [SD_W-1:0]  CLIP_LIMIT_RESET  = SD_W'(655360);
  localparam logic [CNT_W-1:0] NUM_COLUMNS_RESET = CNT_W'(2);
  localparam logic [CNT_W-1:0] MIN_ROW_LEN       = CNT_W'(2);

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic signed [VAL_W-1:0] row_mean;
    logic [SD_W-1:0]         row_sd;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] row_variance;
    logic             zero_spread;
  } out_item_t;

  // Divider control: load a new problem, or run one quotient step
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ===== hw/rtl/csrv_div.sv =====
// ----------------------------------------------------------------------------
// csrv_div: shared radix-2 restoring divider
// One quotient bit per step. The dividend shifts out of the top of a
// 64-bit register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module csrv_div import csrv_pkg::*; (
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [SD_W-1:0]  load_rem,
  input  logic [ACC_W-1:0] load_quot,
  input  logic [SD_W-1:0]  load_divisor,
  output logic [ACC_W-1:0] quot
);

  logic [SD_W-1:0]  rem;
  logic [SD_W-1:0]  divisor;
  logic [SD_W:0]    trial;
  logic [SD_W:0]    trial_diff;
  logic             fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial      = {rem, quot[ACC_W-1]};
    trial_diff = trial - {1'b0, divisor};
    fits       = trial >= {1'b0, divisor};
  end

  // Load a problem or advance one step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem     <= load_rem;
      quot    <= load_quot;
      divisor <= load_divisor;
    end else if (ctrl.step) begin
      rem  <= fits ? trial_diff[SD_W-1:0] : trial[SD_W-1:0];
      quot <= {quot[ACC_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/clipped_standardized_row_variance.sv =====
// ----------------------------------------------------------------------------
// clipped_standardized_row_variance: streamed clipped standardized variance
// Forms z = (value - mean) / sd per sample, saturates and clips it, adds
// z squared into a saturating accumulator and emits sum / (n - 1) per row.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_data  (in_item_t)
//   out      out  out_valid / out_ready  out_data (out_item_t)
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// A sample passes through transfer, setup, divider steps for z (none if
// z saturates), magnitude, square, accumulate and count; a zero sd skips
// to the count. A row end without a zero sd adds the row division steps.
// Synchronous reset clears the accumulator, row count and output valid,
// and reloads the config registers. A sample is taken while the output
// register is full, but not while a finished result waits to load it.
// ----------------------------------------------------------------------------
module clipped_standardized_row_variance import csrv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SD_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_ZDIV = 3'd2;
  localparam logic [2:0] S_MAG  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_CNT  = 3'd6;
  localparam logic [2:0] S_FDIV = 3'd7;
  // S_OUT shares no code: result load happens from S_FDIV end or S_CNT
  // through the res_pend flag below.

  logic [2:0]        state;
  logic [SD_W-1:0]   clip_limit;
  logic [CNT_W-1:0]  num_columns;
  logic [ACC_W-1:0]  square_sum;
  logic [CNT_W-1:0]  sample_count;
  logic              spread_zero;

  logic [DIFF_W-1:0] diff;
  logic [SD_W-1:0]   sd;
  logic              neg;
  logic              zsat;
  logic [VAL_W-1:0]  zmag;
  logic [ACC_W-1:0]  square;
  logic [ITER_W-1:0] iter;
  logic              res_pend;
  logic              res_zero;

  logic [DIFF_W-1:0] mag;
  logic [DIVD_W-1:0] dividend;
  logic [HI_W-1:0]   dividend_hi;
  logic              prep_sat;
  logic [SD_W-1:0]   zq;
  logic [SD_W-1:0]   zpos;
  logic [VAL_W-1:0]  zmag_next;
  logic [ACC_W:0]    sum_wide;
  logic [CNT_W-1:0]  row_len;
  logic [CNT_W-1:0]  cnt_inc;
  logic              row_end;
  logic              out_free;

  div_ctrl_t         div_ctrl;
  logic [SD_W-1:0]   div_rem;
  logic [ACC_W-1:0]  div_quot_in;
  logic [SD_W-1:0]   div_divisor;
  logic [ACC_W-1:0]  quot;

  assign in_ready = (state == S_IDLE) && !res_pend;
  assign out_free = !out_valid || out_ready;

  // Setup: magnitude of the difference, scaled dividend, overflow check
  always_comb begin
    mag         = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
    dividend    = {mag, {FRAC_BITS{1'b0}}};
    dividend_hi = dividend[DIVD_W-1:ZQ_BITS];
    prep_sat    = {{(SD_W-HI_W){1'b0}}, dividend_hi} >= sd;
  end

  // Saturate z, clip positive values, take the magnitude
  always_comb begin
    zq   = quot[ZQ_BITS-1:0];
    zpos = zsat ? {SD_W{1'b1}} : zq;
    if (neg) begin
      zmag_next = zsat ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, zq};
    end else begin
      zmag_next = {1'b0, (zpos > clip_limit) ? clip_limit : zpos};
    end
  end

  // Row bookkeeping
  always_comb begin
    sum_wide = {1'b0, square_sum} + {1'b0, square};
    row_len  = (num_columns < MIN_ROW_LEN) ? MIN_ROW_LEN : num_columns;
    cnt_inc  = sample_count + CNT_W'(1);
    row_end  = (cnt_inc == '0) || (cnt_inc >= row_len);
  end

  // Divider loads: z problem in setup, row division at row end
  always_comb begin
    div_ctrl    = '0;
    div_rem     = '0;
    div_quot_in = '0;
    div_divisor = '0;
    case (state)
      S_PREP: begin
        div_ctrl.load = (sd != '0) && !prep_sat;
        div_rem       = {{(SD_W-HI_W){1'b0}}, dividend_hi};
        div_quot_in   = {dividend[ZQ_BITS-1:0], {(ACC_W-ZQ_BITS){1'b0}}};
        div_divisor   = sd;
      end
      S_CNT: begin
        div_ctrl.load = row_end && !spread_zero;
        div_quot_in   = square_sum;
        div_divisor   = {{(SD_W-CNT_W){1'b0}}, row_len - CNT_W'(1)};
      end
      S_ZDIV, S_FDIV: begin
        div_ctrl.step = 1'b1;
      end
      default: begin
        div_ctrl = '0;
      end
    endcase
  end

  csrv_div u_div (
    .clk          (clk),
    .ctrl         (div_ctrl),
    .load_rem     (div_rem),
    .load_quot    (div_quot_in),
    .load_divisor (div_divisor),
    .quot         (quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit  <= CLIP_LIMIT_RESET;
      num_columns <= NUM_COLUMNS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LIMIT:  clip_limit  <= cfg_data;
        CFG_NUM_COLUMNS: num_columns <= cfg_data[CNT_W-1:0];
        default: begin
          clip_limit <= clip_limit;
        end
      endcase
    end
  end

  // Sequencer and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      square_sum   <= '0;
      sample_count <= '0;
      spread_zero  <= 1'b0;
      res_pend     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Move a finished result into the output register, else drop the
      // result once the consumer takes it
      if (res_pend && out_free) begin
        out_valid             <= 1'b1;
        out_data.zero_spread  <= res_zero;
        out_data.row_variance <= res_zero ? '0 : quot;
        res_pend              <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            diff  <= DIFF_W'(in_data.sample_value) - DIFF_W'(in_data.row_mean);
            sd    <= in_data.row_sd;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          neg  <= diff[DIFF_W-1];
          zsat <= prep_sat;
          iter <= ITER_W'(ZQ_BITS - 1);
          if (sd == '0) begin
            spread_zero <= 1'b1;
            state       <= S_CNT;
          end else if (prep_sat) begin
            state <= S_MAG;
          end else begin
            state <= S_ZDIV;
          end
        end
        S_ZDIV: begin
          iter <= iter - ITER_W'(1);
          if (iter == '0) begin
            state <= S_MAG;
          end
        end
        S_MAG: begin
          zmag  <= zmag_next;
          state <= S_SQR;
        end
        S_SQR: begin
          square <= ACC_W'(zmag) * ACC_W'(zmag);
          state  <= S_ACC;
        end
        S_ACC: begin
          square_sum <= sum_wide[ACC_W] ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
          state      <= S_CNT;
        end
        S_CNT: begin
          if (!row_end) begin
            sample_count <= cnt_inc;
            state        <= S_IDLE;
          end else if (spread_zero) begin
            // Hold while a result is still pending before closing the row
            if (!res_pend) begin
              res_zero     <= 1'b1;
              res_pend     <= 1'b1;
              square_sum   <= '0;
              sample_count <= '0;
              spread_zero  <= 1'b0;
              state        <= S_IDLE;
            end
          end else begin
            res_zero     <= 1'b0;
            iter         <= ITER_W'(ACC_W - 1);
            square_sum   <= '0;
            sample_count <= '0;
            state        <= S_FDIV;
          end
        end
        S_FDIV: begin
          iter <= iter - ITER_W'(1);
          if (iter == '0) begin
            res_pend <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_clipped_standardized_row_variance.sv =====
// ----------------------------------------------------------------------------
// tb_clipped_standardized_row_variance: self-checking bench for the block
// Streams samples through the input channel under random idle and stall
// bursts, and predicts each row result in step with the accepted samples.
// Every result transfer is checked field by field against the oldest
// prediction. Directed rows hit the saturation, clip, zero-sd, rounding and
// row-length corners, and random phases then sweep the two registers.
// ----------------------------------------------------------------------------
module tb_clipped_standardized_row_variance;
  import csrv_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 600;
  localparam logic [SD_W-1:0] SD_MAX = {SD_W{1'b1}};
  localparam logic [SD_W-1:0] COLS_MAX = SD_W'({CNT_W{1'b1}});

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_CLIP_LIMIT;
  logic [SD_W-1:0] cfg_data = '0;

  // Stimulus backlog and expected row results
  in_item_t sample_backlog[$];
  out_item_t pending_variances[$];
  int samples_queued = 0;
  int samples_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Handshake bookkeeping for driver and receiver
  logic in_taken = 1'b0;
  int idle_left = 0;
  int stall_left = 0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_on = 1'b0;

  // Predictor copy of registers and row state
  logic [SD_W-1:0] clip_cfg = CLIP_LIMIT_RESET;
  logic [CNT_W-1:0] cols_cfg = NUM_COLUMNS_RESET;
  longint unsigned sq_sum = 0;
  logic [CNT_W-1:0] row_pos = '0;
  logic saw_zero_sd = 1'b0;

  clipped_standardized_row_variance u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Standardize, saturate, clip, square and accumulate one sample;
  // close the row and predict its variance once the count is reached
  function automatic void accumulate_sample(in_item_t s);
    longint signed diff;
    longint signed z;
    longint unsigned mag;
    longint unsigned quot;
    longint unsigned sd_wide;
    longint unsigned zmag;
    longint unsigned sum;
    longint unsigned row_len;
    out_item_t res;
    row_len = (cols_cfg < MIN_ROW_LEN) ? longint'(MIN_ROW_LEN) : longint'(cols_cfg);
    if (s.row_sd == '0) begin
      saw_zero_sd = 1'b1;
    end else begin
      diff = longint'($signed(s.sample_value)) - longint'($signed(s.row_mean));
      mag = (diff < 0) ? -diff : diff;
      sd_wide = 64'(s.row_sd);
      quot = (mag << FRAC_BITS) / sd_wide;
      if (diff < 0) begin
        if (quot > 64'h8000_0000) quot = 64'h8000_0000;
        z = -longint'(quot);
      end else begin
        if (quot > 64'h7FFF_FFFF) quot = 64'h7FFF_FFFF;
        z = quot;
      end
      // Clip from above only
      if (z > longint'(clip_cfg)) z = longint'(clip_cfg);
      zmag = (z < 0) ? -z : z;
      sum = sq_sum + zmag * zmag;
      sq_sum = (sum < sq_sum) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
    end
    row_pos = row_pos + CNT_W'(1);
    if (row_pos != '0 && row_pos < row_len) return;
    res.zero_spread = saw_zero_sd;
    res.row_variance = saw_zero_sd ? 64'd0 : sq_sum / (row_len - 1);
    pending_variances.push_back(res);
    sq_sum = 0;
    row_pos = '0;
    saw_zero_sd = 1'b0;
  endfunction

  task automatic check_variance(out_item_t got);
    out_item_t want;
    if (pending_variances.size() == 0) begin
      flag_mismatch($sformatf("unexpected result variance=%h zero_spread=%b",
                              got.row_variance, got.zero_spread));
      return;
    end
    want = pending_variances.pop_front();
    if (got.row_variance !== want.row_variance)
      flag_mismatch($sformatf("row_variance got %h want %h",
                              got.row_variance, want.row_variance));
    if (got.zero_spread !== want.zero_spread)
      flag_mismatch($sformatf("zero_spread got %b want %b",
                              got.zero_spread, want.zero_spread));
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        accumulate_sample(in_data);
        samples_taken++;
      end
      if (out_valid && out_ready) check_variance(out_data);
    end
  end

  // Drive the input channel: hold until transfer, then idle or advance
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (idle_left != 0) begin
      idle_left <= idle_left - 1;
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      idle_left <= $urandom_range(0, 16);
      in_valid <= 1'b0;
    end else if (sample_backlog.size() != 0) begin
      in_data <= sample_backlog.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Drive the result ready with random stall bursts
  always @(negedge clk) begin
    if (rst || hold_on) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** clipped_standardized_row_variance: FAILED **");
      $finish;
    end
  end

  task automatic set_reg(logic idx, logic [SD_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CLIP_LIMIT) clip_cfg = value;
    else cols_cfg = value[CNT_W-1:0];
  endtask

  task automatic queue_sample(logic [31:0] value, logic [31:0] mean, logic [SD_W-1:0] sd);
    in_item_t s;
    s.sample_value = value;
    s.row_mean = mean;
    s.row_sd = sd;
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  // Wait for every transfer and result, then let a partial-row sample finish
  task automatic settle();
    while (samples_taken != samples_queued) @(negedge clk);
    while (pending_variances.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic in_item_t random_sample();
    in_item_t s;
    int k;
    int offset;
    int unsigned pick;
    pick = $urandom_range(0, 29);
    s.row_mean = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    s.row_sd = SD_W'($urandom_range(32'h0000_1000, 32'h0010_0000));
    k = $urandom_range(0, 96);
    offset = ((k - 48) * int'(s.row_sd)) / 4;
    s.sample_value = s.row_mean + offset + int'($urandom_range(0, 255));
    case (pick)
      0, 1, 2: begin
        s.sample_value = $urandom;
        s.row_mean = $urandom;
        s.row_sd = SD_W'($urandom);
      end
      3: s.row_sd = '0;
      4: begin
        s.sample_value = $urandom;
        s.row_mean = $urandom;
        s.row_sd = SD_W'($urandom_range(1, 15));
      end
      5: s.row_sd = SD_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
      default: ;
    endcase
    return s;
  endfunction

  initial begin : stimulus
    int n_items;
    logic [SD_W-1:0] clip_pick;
    logic [SD_W-1:0] cols_pick;
    in_item_t s;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: clip at 10.0, rows of two
    // Saturated positive z gets clipped; saturated negative z is not
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
    // Zero difference with the widest sd, then truncated quotients
    queue_sample(32'h0001_2345, 32'h0001_2345, SD_MAX);
    queue_sample(32'd0, 32'd1, 31'd3);
    queue_sample(32'd1, 32'd0, 31'd3);
    queue_sample(32'h0003_0000, 32'h0001_0000, 31'h0000_8000);
    // Zero sd anywhere in the row forces a flagged zero
    queue_sample(32'h0002_0000, 32'h0001_0000, 31'd0);
    queue_sample(32'hFFFE_0000, 32'h0001_0000, 31'h0001_0000);
    // z exactly at the clip, then just above it
    queue_sample(32'h000A_0000, 32'd0, 31'h0001_0000);
    queue_sample(32'h000B_0000, 32'd0, 31'h0001_0000);
    settle();

    // Widest clip and six full-scale squares overflow the accumulator
    set_reg(CFG_CLIP_LIMIT, SD_MAX);
    set_reg(CFG_NUM_COLUMNS, SD_W'(6));
    repeat (3) begin
      queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 31'd1);
      queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
    end
    settle();

    // Zero clip flattens positive z only
    set_reg(CFG_CLIP_LIMIT, '0);
    set_reg(CFG_NUM_COLUMNS, SD_W'(2));
    queue_sample(32'h0005_0000, 32'd0, 31'h0001_0000);
    queue_sample(32'hFFFB_0000, 32'd0, 31'h0001_0000);
    settle();

    // Row lengths of zero and one act as two
    set_reg(CFG_CLIP_LIMIT, CLIP_LIMIT_RESET);
    set_reg(CFG_NUM_COLUMNS, '0);
    queue_sample(32'h0001_8000, 32'h0000_8000, 31'h0000_4000);
    queue_sample(32'hFFFF_0000, 32'h0000_8000, 31'h0000_4000);
    settle();
    set_reg(CFG_NUM_COLUMNS, SD_W'(1));
    queue_sample(32'h0000_1000, 32'h0000_2000, 31'h0000_0800);
    queue_sample(32'h0004_0000, 32'h0000_2000, 31'h0003_0000);
    settle();

    // Longest row left partial, then shortened so the next sample ends it
    set_reg(CFG_NUM_COLUMNS, COLS_MAX);
    queue_sample(32'h0002_0000, 32'd0, 31'h0001_0000);
    queue_sample(32'hFFFD_0000, 32'd0, 31'h0001_0000);
    queue_sample(32'h0000_4000, 32'd0, 31'h0001_0000);
    settle();
    set_reg(CFG_NUM_COLUMNS, SD_W'(3));
    queue_sample(32'h0001_0000, 32'd0, 31'h0000_8000);
    settle();

    // Random phases; rows spill across phases, so lengths change mid-row
    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 5))
        0: clip_pick = '0;
        1: clip_pick = SD_MAX;
        2: clip_pick = SD_W'($urandom);
        3: clip_pick = SD_W'($urandom_range(0, 32'h0010_0000));
        default: clip_pick = CLIP_LIMIT_RESET;
      endcase
      case ($urandom_range(0, 9))
        0: cols_pick = SD_W'(2);
        1: cols_pick = SD_W'($urandom_range(0, 1));
        2: cols_pick = SD_W'($urandom_range(10, 24));
        default: cols_pick = SD_W'($urandom_range(2, 8));
      endcase
      if (phase == 1) cols_pick = SD_W'(2);
      set_reg(CFG_CLIP_LIMIT, clip_pick);
      set_reg(CFG_NUM_COLUMNS, cols_pick);
      if (phase == 1) hold_go = 1'b1;
      if (phase == 8) calm = 1'b1;
      n_items = $urandom_range(35, 55);
      repeat (n_items) begin
        s = random_sample();
        queue_sample(s.sample_value, s.row_mean, s.row_sd);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("** clipped_standardized_row_variance: PASSED **");
    end else begin
      $display("** clipped_standardized_row_variance: FAILED **");
    end
    $finish;
  end

endmodule
